// ===== rtl/core/ostb_pkg.sv =====
// shared types and constants of the one-shot timer bank
package ostb_pkg;

  // widths fixed by the item fields
  localparam int unsigned ID_W     = 8;
  localparam int unsigned TICK_W   = 32;
  localparam int unsigned CODE_W   = 8;
  localparam int unsigned ARG_W    = 32;
  localparam int unsigned SPACE_W  = 4;
  localparam int unsigned MS_W     = 16;
  localparam int unsigned EVT_ID_W = 3;

  // most expiry events one tick may emit
  localparam logic [SPACE_W-1:0] MAX_EVENTS = 4'd8;

  // configuration register indexes
  localparam logic [7:0] CFG_TICK_MS   = 8'd0;
  localparam logic [7:0] CFG_EVENT_LIM = 8'd1;

  // reset values of the configuration registers
  localparam logic [MS_W-1:0]   TICK_MS_RST   = 16'd10;
  localparam logic [CODE_W-1:0] EVENT_LIM_RST = 8'd16;

  typedef enum logic [1:0] {
    FUNC_SET    = 2'd0,
    FUNC_CANCEL = 2'd1,
    FUNC_QUERY  = 2'd2,
    FUNC_TICK   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    KIND_REPLY   = 2'd0,
    KIND_EVENT   = 2'd1,
    KIND_NOEVENT = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_ROT,
    ST_DONE
  } state_e;

  // contents of one timer cell
  typedef struct packed {
    logic              armed;
    logic [TICK_W-1:0] ticks;
    logic [CODE_W-1:0] code;
    logic [ARG_W-1:0]  arg;
  } timer_t;

  // one result item
  typedef struct packed {
    kind_e               kind;
    logic                ok;
    logic                act;
    logic [TICK_W-1:0]   rem;
    logic [EVT_ID_W-1:0] tmr;
    logic [CODE_W-1:0]   code;
    logic [ARG_W-1:0]    arg;
    logic                last;
  } result_t;

endpackage

// ===== rtl/core/ostb_cell.sv =====
// one timer cell of the rotating ring
module ostb_cell
  import ostb_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   shift_i,
  input  timer_t d_i,
  output timer_t q_o
);

  timer_t cell_q;

  // take the neighbor's contents on every shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (shift_i) begin
      cell_q <= d_i;
    end
  end

  assign q_o = cell_q;

endmodule

// ===== rtl/core/ostb_div.sv =====
// bit-serial divider turning a delay in ms into a rounded-up tick count
module ostb_div
  import ostb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [TICK_W-1:0] dividend_i,
  input  logic [MS_W-1:0]   divisor_i,
  output logic              done_o,
  output logic [TICK_W-1:0] ticks_o
);

  localparam int unsigned STEP_W = $clog2(TICK_W);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [MS_W-1:0]   rem_q;
  logic [TICK_W-1:0] quo_q;
  logic [MS_W-1:0]   div_q;
  logic [MS_W:0]     rem_shift;
  logic [MS_W:0]     trial;
  logic [TICK_W-1:0] ceil_ticks;

  // one restoring step per cycle
  assign rem_shift = {rem_q, quo_q[TICK_W-1]};
  assign trial     = rem_shift - {1'b0, div_q};

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == STEP_W'(TICK_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      if (!trial[MS_W]) begin
        rem_q <= trial[MS_W-1:0];
        quo_q <= {quo_q[TICK_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_shift[MS_W-1:0];
        quo_q <= {quo_q[TICK_W-2:0], 1'b0};
      end
    end
  end

  // round up, at least one tick
  always_comb begin
    ceil_ticks = quo_q + TICK_W'(rem_q != '0);
    if (ceil_ticks == '0) begin
      ceil_ticks = TICK_W'(1);
    end
  end

  assign done_o  = done_q;
  assign ticks_o = ceil_ticks;

endmodule

// ===== rtl/core/one_shot_timer_bank_core.sv =====
// top level of the one-shot timer bank: ring of timer cells and head logic
//
// The timers sit in a ring of TIMERS cells that rotates one place per cycle
// while an item is worked on and no stall holds it; all updates happen at
// the head cell, so every cancel, query and tick turns the ring once, a
// rejected set goes straight to its result, and an accepted set first has
// its delay divided by the tick length in a one-bit-per-cycle divider. A
// tick that emits several events holds the ring for as long as the previous
// event still waits in the full output register, and every item waits in
// its last cycle until the output register is free.
// tick_ms of zero counts as one; event codes outside 1..event_limit-1
// make a set fail. Results leave through a registered output, so the next
// item is taken while the last result still waits.
module one_shot_timer_bank_core
  import ostb_pkg::*;
#(
  parameter int unsigned TIMERS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [7:0]          cfg_idx_i,
  input  logic [MS_W-1:0]     cfg_data_i,
  // input items
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          func_i,
  input  logic [ID_W-1:0]     timer_id_i,
  input  logic [TICK_W-1:0]   delay_ms_i,
  input  logic [CODE_W-1:0]   event_code_i,
  input  logic [ARG_W-1:0]    event_arg_i,
  input  logic [SPACE_W-1:0]  queue_space_i,
  // result items
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          kind_o,
  output logic                ok_o,
  output logic                is_active_o,
  output logic [TICK_W-1:0]   remaining_ms_o,
  output logic [EVT_ID_W-1:0] event_timer_o,
  output logic [CODE_W-1:0]   out_code_o,
  output logic [ARG_W-1:0]    out_arg_o,
  output logic                last_o
);

  localparam int unsigned CNT_W = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(TIMERS - 1);

  state_e state_q, state_d;

  logic [MS_W-1:0]    tick_ms_q;
  logic [CODE_W-1:0]  event_lim_q;
  logic [MS_W-1:0]    tick_eff;

  func_e              func_q;
  logic [ID_W-1:0]    id_q;
  logic [CODE_W-1:0]  code_q;
  logic [ARG_W-1:0]   arg_q;
  logic [SPACE_W-1:0] space_q;
  logic               ok_q;
  logic [TICK_W-1:0]  set_ticks_q;
  logic [CNT_W-1:0]   cnt_q;

  logic                pend_valid_q;
  logic [EVT_ID_W-1:0] pend_tmr_q;
  logic [CODE_W-1:0]   pend_code_q;
  logic [ARG_W-1:0]    pend_arg_q;

  logic              qry_act_q;
  logic [TICK_W-1:0] qry_rem_q;

  result_t out_q, res_d;
  logic    out_valid_q;
  logic    out_free;
  logic    out_load;

  logic               in_accept;
  logic               set_ok_in;
  logic               div_start;
  logic               div_done;
  logic [TICK_W-1:0]  div_ticks;
  logic               shift;
  logic               stall;
  logic               fire;
  logic               id_hit;
  logic [TICK_W-1:0]  dec;
  logic [47:0]        qry_prod;
  logic [SPACE_W-1:0] space_sat;

  timer_t cell_q [TIMERS];
  timer_t cell_d [TIMERS];
  timer_t head;
  timer_t head_d;

  // handshakes
  assign cfg_ready_o = 1'b1;
  assign in_accept   = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  assign tick_eff  = (tick_ms_q == '0) ? MS_W'(1) : tick_ms_q;
  assign set_ok_in = (timer_id_i < ID_W'(TIMERS)) && (event_code_i != '0) &&
                     (event_code_i < event_lim_q);
  assign space_sat = (queue_space_i > MAX_EVENTS) ? MAX_EVENTS : queue_space_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_ms_q   <= TICK_MS_RST;
      event_lim_q <= EVENT_LIM_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_i)
        CFG_TICK_MS:   tick_ms_q   <= cfg_data_i;
        CFG_EVENT_LIM: event_lim_q <= cfg_data_i[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  // ring of timer cells, the head feeds the tail
  for (genvar k = 0; k < TIMERS; k++) begin : g_ring
    if (k == TIMERS - 1) begin : g_tail
      assign cell_d[k] = head_d;
    end else begin : g_mid
      assign cell_d[k] = cell_q[k+1];
    end
    ostb_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .d_i     (cell_d[k]),
      .q_o     (cell_q[k])
    );
  end

  assign head = cell_q[0];

  // delay to tick conversion
  ostb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (delay_ms_i),
    .divisor_i  (tick_eff),
    .done_o     (div_done),
    .ticks_o    (div_ticks)
  );

  // head cell update
  assign id_hit   = (id_q == ID_W'(cnt_q));
  assign dec      = (head.ticks != '0) ? head.ticks - TICK_W'(1) : '0;
  assign qry_prod = head.ticks * tick_eff;

  always_comb begin
    head_d = head;
    fire   = 1'b0;
    case (func_q)
      FUNC_SET: begin
        if (id_hit && ok_q) begin
          head_d.armed = 1'b1;
          head_d.ticks = set_ticks_q;
          head_d.code  = code_q;
          head_d.arg   = arg_q;
        end
      end
      FUNC_CANCEL: begin
        if (id_hit) begin
          head_d.armed = 1'b0;
          head_d.ticks = '0;
        end
      end
      FUNC_TICK: begin
        if (head.armed) begin
          head_d.ticks = dec;
          if ((dec == '0) && (space_q != '0)) begin
            fire         = 1'b1;
            head_d.armed = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (func_e'(func_i) == FUNC_SET) begin
            state_d = set_ok_in ? ST_DIV : ST_DONE;
          end else begin
            state_d = ST_ROT;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_ROT;
        end
      end
      ST_ROT: begin
        if (shift && (cnt_q == LAST_POS)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs and result selection
  always_comb begin
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    shift      = 1'b0;
    stall      = 1'b0;
    out_load   = 1'b0;
    res_d      = '0;
    res_d.kind = KIND_REPLY;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        div_start  = in_valid_i && (func_e'(func_i) == FUNC_SET) && set_ok_in;
      end
      ST_ROT: begin
        stall = fire && pend_valid_q && !out_free;
        shift = !stall;
        if (fire && pend_valid_q && out_free) begin
          out_load   = 1'b1;
          res_d.kind = KIND_EVENT;
          res_d.tmr  = pend_tmr_q;
          res_d.code = pend_code_q;
          res_d.arg  = pend_arg_q;
          res_d.last = 1'b0;
        end
      end
      ST_DONE: begin
        out_load   = out_free;
        res_d.last = 1'b1;
        case (func_q)
          FUNC_SET: res_d.ok = ok_q;
          FUNC_QUERY: begin
            res_d.act = qry_act_q;
            res_d.rem = qry_rem_q;
          end
          FUNC_TICK: begin
            if (pend_valid_q) begin
              res_d.kind = KIND_EVENT;
              res_d.tmr  = pend_tmr_q;
              res_d.code = pend_code_q;
              res_d.arg  = pend_arg_q;
            end else begin
              res_d.kind = KIND_NOEVENT;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      func_q       <= FUNC_SET;
    end else begin
      state_q <= state_d;
      if (in_accept) begin
        func_q       <= func_e'(func_i);
        cnt_q        <= '0;
        pend_valid_q <= 1'b0;
      end
      if (shift) begin
        cnt_q <= (cnt_q == LAST_POS) ? '0 : cnt_q + 1'b1;
        if (fire) begin
          pend_valid_q <= 1'b1;
        end
      end
      if ((state_q == ST_DONE) && out_free) begin
        pend_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item payload and working registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      id_q    <= timer_id_i;
      code_q  <= event_code_i;
      arg_q   <= event_arg_i;
      space_q <= space_sat;
      ok_q    <= set_ok_in;
    end
    if (div_done) begin
      set_ticks_q <= div_ticks;
    end
    if (shift) begin
      if (fire) begin
        space_q     <= space_q - 1'b1;
        pend_tmr_q  <= EVT_ID_W'(cnt_q);
        pend_code_q <= head.code;
        pend_arg_q  <= head.arg;
      end
      if ((func_q == FUNC_QUERY) && id_hit) begin
        qry_act_q <= head.armed;
        qry_rem_q <= qry_prod[TICK_W-1:0];
      end
    end
    if (in_accept && (timer_id_i >= ID_W'(TIMERS))) begin
      qry_act_q <= 1'b0;
      qry_rem_q <= '0;
    end
    if (out_load) begin
      out_q <= res_d;
    end
  end

  // result ports
  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_q.kind;
  assign ok_o           = out_q.ok;
  assign is_active_o    = out_q.act;
  assign remaining_ms_o = out_q.rem;
  assign event_timer_o  = out_q.tmr;
  assign out_code_o     = out_q.code;
  assign out_arg_o      = out_q.arg;
  assign last_o         = out_q.last;

endmodule

// ===== test/tb.sv =====
// testbench of the one-shot timer bank: predictor, checker and stimulus
`timescale 1ns / 100ps

module tb;
  import ostb_pkg::*;

  localparam int unsigned TIMERS        = 8;
  localparam int unsigned SETTLE_CYCLES = TIMERS + 40;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned SEGMENTS      = 6;
  localparam int unsigned SEG_ITEMS     = 34;

  // one operation item as driven on the input side
  typedef struct {
    func_e               func;
    logic [ID_W-1:0]     id;
    logic [TICK_W-1:0]   delay;
    logic [CODE_W-1:0]   code;
    logic [ARG_W-1:0]    arg;
    logic [SPACE_W-1:0]  space;
  } op_item_t;

  // timer bank mirror and the results it still owes
  class timer_scoreboard;
    logic [TICK_W-1:0] ticks_left [TIMERS];
    logic [CODE_W-1:0] code_of [TIMERS];
    logic [ARG_W-1:0]  arg_of [TIMERS];
    logic              armed [TIMERS];
    logic [MS_W-1:0]   tick_ms;
    logic [CODE_W-1:0] event_limit;
    result_t           due_results [$];
    int                errors;

    function new();
      for (int i = 0; i < TIMERS; i++) begin
        ticks_left[i] = '0;
        code_of[i] = '0;
        arg_of[i] = '0;
        armed[i] = 1'b0;
      end
      tick_ms = TICK_MS_RST;
      event_limit = EVENT_LIM_RST;
      errors = 0;
    endfunction

    // zero tick length counts as one
    function logic [MS_W-1:0] eff_tick();
      return (tick_ms == '0) ? MS_W'(1) : tick_ms;
    endfunction

    function void note_config(logic [7:0] idx, logic [MS_W-1:0] data);
      case (idx)
        CFG_TICK_MS:   tick_ms = data;
        CFG_EVENT_LIM: event_limit = data[CODE_W-1:0];
        default: ;
      endcase
    endfunction

    // work out the results one accepted item causes
    function void note_item(op_item_t it);
      result_t           r;
      logic [TICK_W-1:0] t;
      logic [TICK_W-1:0] q;
      logic [SPACE_W-1:0] space;
      logic              idx_ok;
      int                n;
      r = '0;
      r.kind = KIND_REPLY;
      r.last = 1'b1;
      idx_ok = (it.id < TIMERS);
      t = TICK_W'(eff_tick());
      case (it.func)
        FUNC_SET: begin
          r.ok = idx_ok && (it.code >= 1) && (it.code < event_limit);
          if (r.ok) begin
            // delay in ticks, rounded up, at least one
            q = it.delay / t;
            if ((it.delay % t) != 0) q = q + 1;
            if (q == 0) q = 1;
            ticks_left[it.id] = q;
            code_of[it.id] = it.code;
            arg_of[it.id] = it.arg;
            armed[it.id] = 1'b1;
          end
          due_results.push_back(r);
        end
        FUNC_CANCEL: begin
          if (idx_ok) begin
            armed[it.id] = 1'b0;
            ticks_left[it.id] = '0;
          end
          due_results.push_back(r);
        end
        FUNC_QUERY: begin
          if (idx_ok) begin
            r.act = armed[it.id];
            r.rem = ticks_left[it.id] * t;
          end
          due_results.push_back(r);
        end
        default: begin
          // tick: count down in index order, emit while space lasts
          space = (it.space > MAX_EVENTS) ? MAX_EVENTS : it.space;
          n = 0;
          for (int i = 0; i < TIMERS; i++) begin
            if (armed[i]) begin
              if (ticks_left[i] > 0) ticks_left[i] = ticks_left[i] - 1;
              if (ticks_left[i] == 0 && space > 0) begin
                space = space - 1'b1;
                armed[i] = 1'b0;
                r = '0;
                r.kind = KIND_EVENT;
                r.tmr = i[EVT_ID_W-1:0];
                r.code = code_of[i];
                r.arg = arg_of[i];
                due_results.push_back(r);
                n++;
              end
            end
          end
          if (n == 0) begin
            r = '0;
            r.kind = KIND_NOEVENT;
            r.last = 1'b1;
            due_results.push_back(r);
          end else begin
            due_results[due_results.size()-1].last = 1'b1;
          end
        end
      endcase
    endfunction

    // compare one accepted result with the oldest one owed
    function void check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        if (errors < 10)
          $display("unexpected result: kind %0d tmr %0d code %h arg %h last %0b",
                   got.kind, got.tmr, got.code, got.arg, got.last);
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (got.kind !== want.kind || got.ok !== want.ok || got.act !== want.act ||
          got.rem !== want.rem || got.tmr !== want.tmr || got.code !== want.code ||
          got.arg !== want.arg || got.last !== want.last) begin
        if (errors < 10) begin
          $display("mismatch exp: kind %0d ok %0b act %0b rem %h tmr %0d code %h arg %h last %0b",
                   want.kind, want.ok, want.act, want.rem, want.tmr, want.code, want.arg,
                   want.last);
          $display("         got: kind %0d ok %0b act %0b rem %h tmr %0d code %h arg %h last %0b",
                   got.kind, got.ok, got.act, got.rem, got.tmr, got.code, got.arg, got.last);
        end
        errors++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [7:0]          cfg_idx_i = '0;
  logic [MS_W-1:0]     cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [1:0]          func_i = '0;
  logic [ID_W-1:0]     timer_id_i = '0;
  logic [TICK_W-1:0]   delay_ms_i = '0;
  logic [CODE_W-1:0]   event_code_i = '0;
  logic [ARG_W-1:0]    event_arg_i = '0;
  logic [SPACE_W-1:0]  queue_space_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [1:0]          kind_o;
  logic                ok_o;
  logic                is_active_o;
  logic [TICK_W-1:0]   remaining_ms_o;
  logic [EVT_ID_W-1:0] event_timer_o;
  logic [CODE_W-1:0]   out_code_o;
  logic [ARG_W-1:0]    out_arg_o;
  logic                last_o;

  timer_scoreboard board;
  result_t         seen_result;
  int              src_idle_pct = 6;
  int              sink_idle_pct = 86;
  int unsigned     cycle_count = 0;

  one_shot_timer_bank_core #(
    .TIMERS(TIMERS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .timer_id_i     (timer_id_i),
    .delay_ms_i     (delay_ms_i),
    .event_code_i   (event_code_i),
    .event_arg_i    (event_arg_i),
    .queue_space_i  (queue_space_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .ok_o           (ok_o),
    .is_active_o    (is_active_o),
    .remaining_ms_o (remaining_ms_o),
    .event_timer_o  (event_timer_o),
    .out_code_o     (out_code_o),
    .out_arg_o      (out_arg_o),
    .last_o         (last_o)
  );

  // clock
  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: take and check items, stall at random
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        seen_result.kind = kind_e'(kind_o);
        seen_result.ok   = ok_o;
        seen_result.act  = is_active_o;
        seen_result.rem  = remaining_ms_o;
        seen_result.tmr  = event_timer_o;
        seen_result.code = out_code_o;
        seen_result.arg  = out_arg_o;
        seen_result.last = last_o;
        board.check_result(seen_result);
      end
      out_ready_i <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  function automatic op_item_t item_of(func_e f, logic [ID_W-1:0] id,
                                       logic [TICK_W-1:0] delay, logic [CODE_W-1:0] code,
                                       logic [ARG_W-1:0] arg, logic [SPACE_W-1:0] space);
    op_item_t it;
    it.func = f;
    it.id = id;
    it.delay = delay;
    it.code = code;
    it.arg = arg;
    it.space = space;
    return it;
  endfunction

  // random item of one operation, mostly well-formed for the current settings
  function automatic op_item_t make_item(func_e f);
    op_item_t          it;
    logic [TICK_W-1:0] t;
    int unsigned       k;
    int unsigned       roll;
    it.func = f;
    it.id = ID_W'(($urandom_range(0, 99) < 85) ? $urandom_range(0, TIMERS-1)
                                               : $urandom_range(0, 255));
    it.delay = $urandom;
    it.code = CODE_W'($urandom_range(0, 255));
    it.arg = $urandom;
    it.space = SPACE_W'($urandom_range(0, 15));
    if (f == FUNC_SET) begin
      t = TICK_W'(board.eff_tick());
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        it.delay = '0;
      end else if (roll >= 15) begin
        // a few ticks, anywhere inside the last tick
        k = $urandom_range(1, 4);
        it.delay = k * t - $urandom_range(0, t - 1);
      end
      if (board.event_limit > 1 && $urandom_range(0, 99) < 85)
        it.code = CODE_W'($urandom_range(1, board.event_limit - 1));
    end
    return it;
  endfunction

  // present one item, with random gaps before it, and wait for accept
  task automatic send_item(op_item_t it);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    func_i        <= it.func;
    timer_id_i    <= it.id;
    delay_ms_i    <= it.delay;
    event_code_i  <= it.code;
    event_arg_i   <= it.arg;
    queue_space_i <= it.space;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_item(it);
  endtask

  // stop sending until every owed result has come and the block is quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (board.due_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [MS_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.note_config(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // random items: bursts that set every timer then tick, and single items
  task automatic run_segment(int count);
    op_item_t    it;
    int          sent;
    int unsigned roll;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 99) < 10) begin
        for (int i = 0; i < TIMERS; i++) begin
          it = make_item(FUNC_SET);
          it.id = ID_W'(i);
          it.delay = $urandom_range(0, board.eff_tick());
          send_item(it);
        end
        send_item(make_item(FUNC_TICK));
        sent += TIMERS + 1;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 30)      send_item(make_item(FUNC_SET));
        else if (roll < 40) send_item(make_item(FUNC_CANCEL));
        else if (roll < 65) send_item(make_item(FUNC_QUERY));
        else                send_item(make_item(FUNC_TICK));
        sent++;
      end
    end
  endtask

  initial begin
    logic [MS_W-1:0] tick_val;
    logic [MS_W-1:0] limit_val;
    board = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part under reset settings
    send_item(item_of(FUNC_QUERY, 8'd0, '0, '0, '0, '0));
    send_item(item_of(FUNC_TICK, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 4'd0));
    send_item(item_of(FUNC_SET, 8'd0, 32'd0, 8'd1, 32'd0, 4'd0));
    send_item(item_of(FUNC_SET, 8'd7, 32'hFFFF_FFFF, 8'd15, 32'hFFFF_FFFF, 4'hF));
    send_item(item_of(FUNC_QUERY, 8'd7, '0, '0, '0, '0));
    // bad index and bad event codes
    send_item(item_of(FUNC_SET, 8'd8, 32'd10, 8'd3, 32'd1, 4'd0));
    send_item(item_of(FUNC_SET, 8'd255, 32'd10, 8'd3, 32'd1, 4'd0));
    send_item(item_of(FUNC_SET, 8'd1, 32'd10, 8'd0, 32'd1, 4'd0));
    send_item(item_of(FUNC_SET, 8'd1, 32'd10, 8'd16, 32'd1, 4'd0));
    send_item(item_of(FUNC_SET, 8'd1, 32'd10, 8'd255, 32'd1, 4'd0));
    send_item(item_of(FUNC_SET, 8'd1, 32'd11, 8'd5, 32'hA5A5_5A5A, 4'd0));
    send_item(item_of(FUNC_SET, 8'd2, 32'd10, 8'd6, 32'h1234_5678, 4'd0));
    // queue full, then partial space, then space above the limit
    send_item(item_of(FUNC_TICK, 8'd0, '0, '0, '0, 4'd0));
    send_item(item_of(FUNC_QUERY, 8'd0, '0, '0, '0, '0));
    send_item(item_of(FUNC_TICK, 8'd0, '0, '0, '0, 4'd1));
    send_item(item_of(FUNC_TICK, 8'd0, '0, '0, '0, 4'd15));
    send_item(item_of(FUNC_CANCEL, 8'd7, '0, '0, '0, '0));
    send_item(item_of(FUNC_QUERY, 8'd7, '0, '0, '0, '0));
    send_item(item_of(FUNC_CANCEL, 8'd200, '0, '0, '0, '0));
    send_item(item_of(FUNC_QUERY, 8'd200, '0, '0, '0, '0));
    // cancel keeps code and argument but clears the count and stops the event
    send_item(item_of(FUNC_SET, 8'd3, 32'd1, 8'd1, 32'hDEAD_BEEF, 4'd0));
    send_item(item_of(FUNC_CANCEL, 8'd3, '0, '0, '0, '0));
    send_item(item_of(FUNC_TICK, 8'd3, '0, '0, '0, 4'd8));
    send_item(item_of(FUNC_QUERY, 8'd3, '0, '0, '0, '0));

    // random segments, each under its own settings
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      settle();
      case (seg)
        0: begin tick_val = 16'd1;     limit_val = 16'd255; end
        1: begin tick_val = 16'hFFFF;  limit_val = 16'd2;   end
        2: begin tick_val = 16'd0;     limit_val = 16'd9;   end
        3: begin
          tick_val  = MS_W'($urandom);
          limit_val = MS_W'($urandom_range(2, 255));
        end
        4: begin tick_val = 16'd2;     limit_val = 16'd0;   end
        default: begin
          tick_val  = MS_W'($urandom);
          limit_val = MS_W'($urandom_range(1, 255));
        end
      endcase
      // upper data bits carry noise for the 8-bit register
      limit_val[MS_W-1:CODE_W] = (MS_W-CODE_W)'($urandom);
      if (seg < 2) begin
        src_idle_pct = 6;
        sink_idle_pct = 86;
      end else if (seg < 4) begin
        src_idle_pct = 86;
        sink_idle_pct = 6;
      end else begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end
      write_reg(CFG_TICK_MS, tick_val);
      write_reg(CFG_EVENT_LIM, limit_val);
      run_segment(SEG_ITEMS);
    end

    settle();
    if (board.errors == 0 && board.due_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
